### hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/plbp_pkg.sv
package plbp_pkg;
   localparam int FRAMES = 16;
   localparam int IDX_W = $clog2(FRAMES);
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int FRAME_W = 6;
   localparam int PAGE_W = 32;
   localparam int PIN_W = 8;
   localparam int CTR_W = 32;

   localparam logic [1:0] OP_FETCH = 2'd0;
   localparam logic [1:0] OP_UNPIN = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_PINQ = 2'd3;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_EVICT = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_RESIDENT = 3'd4;
   localparam logic [2:0] ST_ABSENT = 3'd5;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [PIN_W-1:0] pins;
      logic [IDX_W-1:0] rank;
   } entry_type;
endpackage

### hdl/pinned_lru_buffer_pool.sv
// Pinned LRU buffer pool.
// The request channel (req_valid/req_ready) carries an opcode and a page number.
// Fetch looks up the page and pins it, filling a free frame or evicting the
// least recent unpinned page on a miss. Unpin lowers a pin count; the flush and
// pin count queries only report. One transaction on the response channel
// (rsp_valid/rsp_ready) answers each request with status, frame, victim page,
// pin count and the running hit and miss counters.
// All frame state sits in one single-port-read memory with a registered read.
// Every request first sweeps all frames to find the page and the least recent
// unpinned candidate. A fetch that changes the pool then sweeps the memory
// again to age the recency ranks; the other requests skip that second sweep.
// One request is worked on at a time; req_ready is high only while idle.
// A stalled response holds its payload and keeps the block from taking the
// next request. Reset empties the pool and clears both counters at once;
// no clearing pass is needed because frames are used in order.
module pinned_lru_buffer_pool (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_opcode,
   input  logic [plbp_pkg::PAGE_W-1:0] req_page_number,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [plbp_pkg::FRAME_W-1:0] rsp_frame,
   output logic [plbp_pkg::PAGE_W-1:0] rsp_victim_page,
   output logic [plbp_pkg::PIN_W-1:0] rsp_pin_count,
   output logic [plbp_pkg::CTR_W-1:0] rsp_hit_count,
   output logic [plbp_pkg::CTR_W-1:0] rsp_miss_count
);
   import plbp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_UPD = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAMES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAMES);

   entry_type mem [FRAMES];
   entry_type rd_q_ff;
   logic we;
   logic [IDX_W-1:0] waddr;
   entry_type wdata;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] nxt_ff, nxt_in;
   logic [CTR_W-1:0] hits_ff, hits_in, miss_ff, miss_in;
   logic [1:0] op_ff, op_in;
   logic [PAGE_W-1:0] pg_ff, pg_in;
   logic hfound_ff, hfound_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   entry_type hent_ff, hent_in;
   logic vfound_ff, vfound_in;
   logic [IDX_W-1:0] vidx_ff, vidx_in;
   entry_type vent_ff, vent_in;
   logic [IDX_W-1:0] tf_ff, tf_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [PIN_W-1:0] tpins_ff, tpins_in;
   logic rv_ff, rv_in;
   logic [2:0] st_ff, st_in;
   logic [FRAME_W-1:0] fr_ff, fr_in;
   logic [PAGE_W-1:0] vp_ff, vp_in;
   logic [PIN_W-1:0] pc_ff, pc_in;
   logic [CTR_W-1:0] hc_ff, hc_in, mc_ff, mc_in;
   logic rd_valid_frame;

   always_ff @(posedge clock) begin
      rd_q_ff <= mem[cnt_ff[IDX_W-1:0]];
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rd_valid_frame = CNT_W'(rd_idx_ff) < nxt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      nxt_in = nxt_ff;
      hits_in = hits_ff;
      miss_in = miss_ff;
      op_in = op_ff;
      pg_in = pg_ff;
      hfound_in = hfound_ff;
      hidx_in = hidx_ff;
      hent_in = hent_ff;
      vfound_in = vfound_ff;
      vidx_in = vidx_ff;
      vent_in = vent_ff;
      tf_in = tf_ff;
      lim_in = lim_ff;
      tpins_in = tpins_ff;
      rv_in = rv_ff;
      st_in = st_ff;
      fr_in = fr_ff;
      vp_in = vp_ff;
      pc_in = pc_ff;
      hc_in = hc_ff;
      mc_in = mc_ff;
      we = 1'b0;
      waddr = rd_idx_ff;
      wdata = rd_q_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               pg_in = req_page_number;
               hfound_in = 1'b0;
               vfound_in = 1'b0;
               cnt_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff < FULL_CNT) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && rd_valid_frame) begin
               if (!hfound_ff && rd_q_ff.page == pg_ff) begin
                  hfound_in = 1'b1;
                  hidx_in = rd_idx_ff;
                  hent_in = rd_q_ff;
               end
               if (rd_q_ff.pins == '0 && (!vfound_ff || rd_q_ff.rank > vent_ff.rank)) begin
                  vfound_in = 1'b1;
                  vidx_in = rd_idx_ff;
                  vent_in = rd_q_ff;
               end
            end
            if (rd_vld_ff && CNT_W'(rd_idx_ff) == LAST) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            vp_in = '0;
            fr_in = '0;
            pc_in = '0;
            state_in = S_RESP;
            rv_in = 1'b1;
            lim_in = FULL_CNT;
            tpins_in = 8'd1;
            if (op_ff == OP_FETCH) begin
               if (hfound_ff) begin
                  hits_in = hits_ff + 1'b1;
                  tf_in = hidx_ff;
                  lim_in = CNT_W'(hent_ff.rank);
                  tpins_in = (hent_ff.pins == '1) ? hent_ff.pins : hent_ff.pins + 1'b1;
                  st_in = ST_HIT;
                  state_in = S_UPD;
                  rv_in = 1'b0;
               end else begin
                  miss_in = miss_ff + 1'b1;
                  if (nxt_ff < FULL_CNT) begin
                     tf_in = nxt_ff[IDX_W-1:0];
                     nxt_in = nxt_ff + 1'b1;
                     st_in = ST_FILL;
                     state_in = S_UPD;
                     rv_in = 1'b0;
                  end else if (vfound_ff) begin
                     tf_in = vidx_ff;
                     lim_in = CNT_W'(vent_ff.rank);
                     vp_in = vent_ff.page;
                     st_in = ST_EVICT;
                     state_in = S_UPD;
                     rv_in = 1'b0;
                  end else begin
                     st_in = ST_FULL;
                  end
               end
               cnt_in = '0;
               hc_in = hits_in;
               mc_in = miss_in;
               fr_in = (st_in == ST_FULL) ? '0 : FRAME_W'(tf_in);
               pc_in = (st_in == ST_FULL) ? '0 : tpins_in;
            end else begin
               hc_in = hits_ff;
               mc_in = miss_ff;
               if (!hfound_ff) begin
                  st_in = ST_ABSENT;
               end else begin
                  st_in = ST_RESIDENT;
                  fr_in = FRAME_W'(hidx_ff);
                  pc_in = hent_ff.pins;
                  if (op_ff == OP_UNPIN && hent_ff.pins != '0) begin
                     pc_in = hent_ff.pins - 1'b1;
                     we = 1'b1;
                     waddr = hidx_ff;
                     wdata = hent_ff;
                     wdata.pins = pc_in;
                  end
               end
            end
         end
         S_UPD: begin
            if (cnt_ff < FULL_CNT) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               we = 1'b1;
               if (rd_idx_ff == tf_ff) begin
                  wdata.page = pg_ff;
                  wdata.pins = tpins_ff;
                  wdata.rank = '0;
               end else if (rd_valid_frame && CNT_W'(rd_q_ff.rank) < lim_ff) begin
                  wdata.rank = rd_q_ff.rank + 1'b1;
               end
               if (CNT_W'(rd_idx_ff) == LAST) begin
                  state_in = S_RESP;
                  rv_in = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               rv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         nxt_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         nxt_ff <= nxt_in;
         hits_ff <= hits_in;
         miss_ff <= miss_in;
         rv_ff <= rv_in;
      end
      rd_idx_ff <= rd_idx_in;
      op_ff <= op_in;
      pg_ff <= pg_in;
      hfound_ff <= hfound_in;
      hidx_ff <= hidx_in;
      hent_ff <= hent_in;
      vfound_ff <= vfound_in;
      vidx_ff <= vidx_in;
      vent_ff <= vent_in;
      tf_ff <= tf_in;
      lim_ff <= lim_in;
      tpins_ff <= tpins_in;
      st_ff <= st_in;
      fr_ff <= fr_in;
      vp_ff <= vp_in;
      pc_ff <= pc_in;
      hc_ff <= hc_in;
      mc_ff <= mc_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_frame = fr_ff;
   assign rsp_victim_page = vp_ff;
   assign rsp_pin_count = pc_ff;
   assign rsp_hit_count = hc_ff;
   assign rsp_miss_count = mc_ff;
endmodule

### hdl/plbp_checker.sv
`include "assert_macros.svh"
module plbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [plbp_pkg::FRAME_W-1:0] rsp_frame,
   input logic [plbp_pkg::PAGE_W-1:0] rsp_victim_page,
   input logic [plbp_pkg::PIN_W-1:0] rsp_pin_count
);
   import plbp_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
   `ASSERT_IMPLY(a_victim_zero, clock, reset, rsp_valid && rsp_status != ST_EVICT, rsp_victim_page == '0)
   `ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_ABSENT), rsp_frame == '0 && rsp_pin_count == '0)
   `ASSERT_IMPLY(a_one_side, clock, reset, rsp_valid, !req_ready)
endmodule

bind pinned_lru_buffer_pool plbp_checker u_plbp_checker (.*);
